[hw/rtl/fmenv_pkg.sv]
`default_nettype none

package fmenv_pkg;

	localparam int OPS    = 16;
	localparam int OP_W   = 4;
	localparam int MAX_CH = 4;

	localparam logic [1:0] LAST_SLOT = 2'd3;
	localparam int         DIR_BIT   = 7;

	// Power-on pitch offsets of the operators that start non-zero.
	localparam logic [7:0] SHIFT_OP4 = 8'd28;
	localparam logic [7:0] SHIFT_OP5 = 8'd12;
	localparam logic [7:0] SHIFT_OP7 = 8'd19;
	localparam logic [7:0] SHIFT_OP8 = 8'd36;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_NOTE    = 2'd1,
		CMD_LOAD    = 2'd2,
		CMD_SILENCE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_AMP_OFFSET     = 2'd0,
		CFG_CHANNEL_ENABLE = 2'd1,
		CFG_VELOCITY_MODE  = 2'd2
	} cfg_idx_t;

	typedef enum logic [0:0] {
		KIND_AMP   = 1'b0,
		KIND_PITCH = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_PITCH = 2'd1,
		ACT_SET   = 2'd2,
		ACT_ZERO  = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_TICK     = 3'd1,
		ST_PITCH    = 3'd2,
		ST_AMP      = 3'd3,
		ST_NOTE_OFF = 3'd4,
		ST_SILENCE  = 3'd5
	} state_t;

	typedef struct packed {
		logic [7:0] pitch_shift;
		logic [7:0] target;
		logic [7:0] step;
		logic [7:0] start;
	} op_param_t;

	typedef struct packed {
		logic       valid;
		cmd_t       cmd;
		logic [1:0] ch;
		logic       note_on;
		logic [7:0] pitch_base;
		logic [7:0] vel;
		logic [3:0] mask;
	} seq_req_t;

	typedef struct packed {
		logic [7:0] offset;
		logic       vmode;
	} seq_cfg_t;

	typedef struct packed {
		logic            en;
		logic [OP_W-1:0] addr;
		logic [7:0]      data;
	} amp_wr_t;

	function automatic int used_ch(input int n);
		return (n < MAX_CH) ? n : MAX_CH;
	endfunction

	function automatic op_param_t param_default(input logic [OP_W-1:0] op);
		op_param_t p;
		p = '0;
		case (op)
			4'd4:    p.pitch_shift = SHIFT_OP4;
			4'd5:    p.pitch_shift = SHIFT_OP5;
			4'd7:    p.pitch_shift = SHIFT_OP7;
			4'd8:    p.pitch_shift = SHIFT_OP8;
			default: p.pitch_shift = 8'd0;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/fm_operator_envelope_engine_unit.sv]
`default_nettype none

// Envelope engine for four-operator FM voices, up to four channels.
// A request is taken on a clock edge where start is high and busy is low.
// Load requests update the operator parameter store and the channel transpose
// in that same edge, produce no results and leave busy low; so does a tick
// when no channel is both held and enabled. Other ticks, note events and
// silence requests are worked by a sequencer that walks the operators one per
// cycle against two memories (operator parameters and amplitudes): each
// operator is read in a cycle, modified and written back in the next, and
// presented in the cycle after that.
// Busy stays high while the operators are walked and until the last issued
// operator has been modified and written back; the next request can be taken
// once it falls. A tick walks every operator in use (16 with four channels)
// and emits only those of held, enabled channels; a note-on walks 8, a
// note-off 1, silence every operator in use. Results follow one per cycle,
// except where a tick skips a channel.
// Each result is shown for one cycle with result_valid high; last marks the
// final result of a request. The receiver cannot stall the results.
// Configuration writes (cfg_valid, always ready) are meant for idle periods.
// Reset clears the held mask and stored state and restores the configuration
// defaults; the memories report their power-on values until written.
module fm_operator_envelope_engine_unit import fmenv_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  cmd,
	input  wire logic [1:0]  channel,
	input  wire logic [1:0]  operator_slot,
	input  wire logic [7:0]  note,
	input  wire logic [7:0]  velocity,
	input  wire logic [7:0]  env_start,
	input  wire logic [7:0]  env_step,
	input  wire logic [7:0]  env_target,
	input  wire logic [7:0]  operator_shift,
	input  wire logic signed [7:0] channel_shift,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	output logic             result_valid,
	output logic [3:0]       operator_index,
	output logic             kind,
	output logic [7:0]       value,
	output logic             last
);

	// Channels that can be addressed; higher channel numbers are ignored.
	localparam logic [3:0] USED_MASK = 4'((1 << used_ch(CHANNELS)) - 1);

	logic [7:0] amp_offset_q;
	logic [3:0] chan_enable_q;
	logic       vel_mode_q;
	logic [3:0] held_q;
	logic [7:0] chan_shift_q [MAX_CH];

	logic       accept;
	logic       ch_ok;
	cmd_t       cmd_in;
	seq_req_t   req;
	seq_cfg_t   seq_cfg;

	logic            param_wr_en;
	op_param_t       param_wr;
	logic [OP_W-1:0] rd_addr;
	op_param_t       param_rd;
	logic [7:0]      amp_rd;
	amp_wr_t         amp_wr;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign cmd_in    = cmd_t'(cmd);
	assign ch_ok     = USED_MASK[channel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_offset_q  <= 8'd0;
			chan_enable_q <= 4'hF;
			vel_mode_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_AMP_OFFSET:     amp_offset_q  <= cfg_data;
				CFG_CHANNEL_ENABLE: chan_enable_q <= cfg_data[3:0];
				CFG_VELOCITY_MODE:  vel_mode_q    <= cfg_data[0];
				default:            vel_mode_q    <= vel_mode_q;
			endcase
		end
	end

	// The held mask follows every note event on an addressable channel, even a
	// disabled one, and silence clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 4'd0;
		end else if (accept) begin
			if (cmd_in == CMD_NOTE && ch_ok) begin
				held_q[channel] <= (note != 8'd0);
			end else if (cmd_in == CMD_SILENCE) begin
				held_q <= 4'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CH; i++) begin
				chan_shift_q[i] <= 8'd0;
			end
		end else if (accept && cmd_in == CMD_LOAD && ch_ok) begin
			chan_shift_q[channel] <= channel_shift;
		end
	end

	// Load requests go straight to the parameter store.
	assign param_wr_en          = accept && cmd_in == CMD_LOAD && ch_ok;
	assign param_wr.pitch_shift = operator_shift;
	assign param_wr.target      = env_target;
	assign param_wr.step        = env_step;
	assign param_wr.start       = env_start;

	// Only requests that produce results start the sequencer: a tick needs at
	// least one held and enabled channel, a note event an addressable and
	// enabled channel.
	always_comb begin
		req.cmd        = cmd_in;
		req.ch         = channel;
		req.note_on    = (note != 8'd0);
		req.pitch_base = note + chan_shift_q[channel];
		req.vel        = velocity;
		req.mask       = chan_enable_q & held_q & USED_MASK;
		case (cmd_in)
			CMD_TICK:    req.valid = accept && (req.mask != 4'd0);
			CMD_NOTE:    req.valid = accept && ch_ok && chan_enable_q[channel];
			CMD_SILENCE: req.valid = accept;
			default:     req.valid = 1'b0;
		endcase
	end

	assign seq_cfg.offset = amp_offset_q;
	assign seq_cfg.vmode  = vel_mode_q;

	fmenv_param_mem u_param_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (param_wr_en),
		.wr_addr ({channel, operator_slot}),
		.wr_data (param_wr),
		.rd_addr (rd_addr),
		.rd_data (param_rd)
	);

	fmenv_amp_mem u_amp_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (amp_wr),
		.rd_addr (rd_addr),
		.rd_data (amp_rd)
	);

	fmenv_seq #(
		.CHANNELS (CHANNELS)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.cfg            (seq_cfg),
		.busy           (busy),
		.rd_addr        (rd_addr),
		.param          (param_rd),
		.amp_rd         (amp_rd),
		.amp_wr         (amp_wr),
		.result_valid   (result_valid),
		.operator_index (operator_index),
		.kind           (kind),
		.value          (value),
		.last           (last)
	);

endmodule

`default_nettype wire

[hw/rtl/fmenv_param_mem.sv]
`default_nettype none

// Operator parameter store. Entries never written read as their power-on values.
module fmenv_param_mem import fmenv_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire logic [OP_W-1:0] wr_addr,
	input  wire op_param_t       wr_data,
	input  wire logic [OP_W-1:0] rd_addr,
	output op_param_t            rd_data
);

	op_param_t       mem [OPS];
	op_param_t       data_q;
	logic [OP_W-1:0] addr_q;
	logic [OPS-1:0]  vld_q;
	logic            rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		data_q <= mem[rd_addr];
		addr_q <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? data_q : param_default(addr_q);

endmodule

`default_nettype wire

[hw/rtl/fmenv_amp_mem.sv]
`default_nettype none

// Amplitude store. Entries never written read as zero.
module fmenv_amp_mem import fmenv_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire amp_wr_t         wr,
	input  wire logic [OP_W-1:0] rd_addr,
	output logic [7:0]           rd_data
);

	logic [7:0]     mem [OPS];
	logic [7:0]     data_q;
	logic [OPS-1:0] vld_q;
	logic           rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? data_q : 8'd0;

endmodule

`default_nettype wire

[hw/rtl/fmenv_seq.sv]
`default_nettype none

// Operator sequencer: issues one memory read per cycle, then modifies and
// writes back each operator in the next cycle and registers its result.
module fmenv_seq import fmenv_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire seq_req_t        req,
	input  wire seq_cfg_t        cfg,
	output logic                 busy,
	output logic [OP_W-1:0]      rd_addr,
	input  wire op_param_t       param,
	input  wire logic [7:0]      amp_rd,
	output amp_wr_t              amp_wr,
	output logic                 result_valid,
	output logic [OP_W-1:0]      operator_index,
	output logic                 kind,
	output logic [7:0]           value,
	output logic                 last
);

	localparam int              NUM_OPS = used_ch(CHANNELS) * 4;
	localparam logic [OP_W-1:0] LAST_OP = OP_W'(NUM_OPS - 1);

	state_t          state_q, state_d;
	logic [OP_W-1:0] op_q, op_d;
	logic [3:0]      mask_q;
	logic [7:0]      pitch_base_q;
	logic [7:0]      vel_q;

	logic            iss_valid;
	act_t            iss_act;
	logic            iss_last;

	logic            valid_s1;
	act_t            act_s1;
	logic [OP_W-1:0] op_s1;
	logic            last_s1;

	logic            res_valid_q;
	logic [OP_W-1:0] res_op_q;
	kind_t           res_kind_q;
	logic [7:0]      res_value_q;
	logic            res_last_q;

	logic [7:0]      new_amp;
	logic [7:0]      diff;
	kind_t           res_kind;
	logic [7:0]      res_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		iss_valid = 1'b0;
		iss_act   = ACT_TICK;
		iss_last  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (req.cmd)
						CMD_TICK: begin
							state_d = ST_TICK;
							op_d    = '0;
						end
						CMD_NOTE: begin
							state_d = req.note_on ? ST_PITCH : ST_NOTE_OFF;
							op_d    = {req.ch, req.note_on ? 2'd0 : LAST_SLOT};
						end
						CMD_SILENCE: begin
							state_d = ST_SILENCE;
							op_d    = '0;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_TICK: begin
				iss_valid = mask_q[op_q[3:2]];
				iss_act   = ACT_TICK;
				iss_last  = (op_q[1:0] == LAST_SLOT)
					&& ((mask_q >> ({1'b0, op_q[3:2]} + 3'd1)) == 4'd0);
				op_d      = op_q + 1'b1;
				if (op_q == LAST_OP) begin
					state_d = ST_IDLE;
				end
			end
			ST_PITCH: begin
				iss_valid = 1'b1;
				iss_act   = ACT_PITCH;
				op_d      = op_q + 1'b1;
				if (op_q[1:0] == LAST_SLOT) begin
					state_d = ST_AMP;
					op_d    = {op_q[3:2], 2'd0};
				end
			end
			ST_AMP: begin
				iss_valid = 1'b1;
				iss_act   = ACT_SET;
				iss_last  = (op_q[1:0] == LAST_SLOT);
				op_d      = op_q + 1'b1;
				if (op_q[1:0] == LAST_SLOT) begin
					state_d = ST_IDLE;
				end
			end
			ST_NOTE_OFF: begin
				iss_valid = 1'b1;
				iss_act   = ACT_ZERO;
				iss_last  = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_SILENCE: begin
				iss_valid = 1'b1;
				iss_act   = ACT_ZERO;
				iss_last  = (op_q == LAST_OP);
				op_d      = op_q + 1'b1;
				if (op_q == LAST_OP) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		if (state_q == ST_IDLE && req.valid) begin
			mask_q       <= req.mask;
			pitch_base_q <= req.pitch_base;
			vel_q        <= req.vel;
		end
		act_s1  <= iss_act;
		op_s1   <= op_q;
		last_s1 <= iss_last;
	end

	assign rd_addr = op_q;
	assign busy    = (state_q != ST_IDLE) || valid_s1;

	always_comb begin
		diff      = param.target - amp_rd;
		new_amp   = 8'd0;
		res_kind  = KIND_AMP;
		case (act_s1)
			ACT_TICK: begin
				new_amp = (diff[DIR_BIT] ^ param.step[DIR_BIT]) ? amp_rd - param.step
					: param.target;
			end
			ACT_PITCH: res_kind = KIND_PITCH;
			ACT_SET: begin
				new_amp = (op_s1[1:0] == LAST_SLOT && cfg.vmode) ? vel_q : param.start;
			end
			ACT_ZERO: new_amp = 8'd0;
			default:  new_amp = 8'd0;
		endcase
		if (res_kind == KIND_PITCH) begin
			res_value = param.pitch_shift + pitch_base_q;
		end else begin
			res_value = {4'd0, new_amp[7:4]} + cfg.offset;
		end
	end

	assign amp_wr.en   = valid_s1 && (res_kind == KIND_AMP);
	assign amp_wr.addr = op_s1;
	assign amp_wr.data = new_amp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			valid_s1    <= iss_valid;
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		res_op_q    <= op_s1;
		res_kind_q  <= res_kind;
		res_value_q <= res_value;
		res_last_q  <= last_s1;
	end

	assign result_valid   = res_valid_q;
	assign operator_index = res_op_q;
	assign kind           = res_kind_q;
	assign value          = res_value_q;
	assign last           = res_last_q;

endmodule

`default_nettype wire
